// ===== sv/assert_macros.svh =====
// Assertion macros shared by the expander RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is high.
`define SSE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also runs through reset.
`define SSE_ASSERT_NR(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/sse_pkg.sv =====
// Types, constants and helpers for the sprite sub-quad expander.
`timescale 1ns / 1ps

package sse_pkg;

  // Default screen geometry and fixed-point format.
  localparam int SCREEN_WIDTH_DEF  = 384;
  localparam int SCREEN_HEIGHT_DEF = 224;
  localparam int FRAC_BITS_DEF     = 4;

  // Item kinds carried on s_tuser.
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_RUN   = 2'd1;
  localparam logic [1:0] OP_WHOLE = 2'd2;

  // Texture coordinate of one in 1.16 fixed point.
  localparam logic [16:0] TEX_ONE = 17'h10000;

  // Serial divider: 25-bit dividend magnitude, 9-bit divisor, one bit a cycle.
  localparam int DIV_W      = 25;
  localparam int DIV_STEPS  = DIV_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int PROD_W     = DIV_W + 1;

  // Unsaturated screen coordinate width.
  localparam int POS_W = DIV_W + 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_STORE,
    ST_MUL,
    ST_LOAD,
    ST_EMIT
  } sse_state_t;

  // Clamp an unsaturated coordinate to 16-bit signed.
  function automatic logic [15:0] sat16(input logic signed [POS_W-1:0] v);
    logic signed [POS_W-1:0] hi_lim;
    logic signed [POS_W-1:0] lo_lim;
    hi_lim = POS_W'(32767);
    lo_lim = POS_W'(-32768);
    if (v > hi_lim) begin
      return 16'h7fff;
    end else if (v < lo_lim) begin
      return 16'h8000;
    end else begin
      return v[15:0];
    end
  endfunction

endpackage

// ===== sv/sprite_subquad_expander_core.sv =====
// Sprite sub-quad expander: start, run and whole-quad items to screen/texture quads.
`timescale 1ns / 1ps
//
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tdata: quad corners, chunk, flip, palette, run; tuser: kind
// m_*       out  m_tvalid/m_tready  tdata: corners, texture corners, palette; tuser: valid
//
// Start, whole-quad and unused items are handled on intake. For a run item, the
// 25-step serial divider runs nine times (texel split, then four screen and
// four texture edges), each edge adding a multiply, load and store state.
// Reset clears the sequencer, the quad-active flag and the output valid flag.
// An item is taken only while the sequencer is idle and the output register is free
// or draining; a finished on-screen run waits in place while the output register is held.

`include "assert_macros.svh"

module sprite_subquad_expander_core #(
  parameter int SCREEN_WIDTH  = sse_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = sse_pkg::SCREEN_HEIGHT_DEF,
  parameter int FRAC_BITS     = sse_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // corner0_x, corner0_y, corner3_x, corner3_y, chunk_width, chunk_height,
  // flip, use_palette, palette_value, run_point, run_size, zero pad
  input  logic [111:0] s_tdata,
  // opcode
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // out_x0, out_y0, out_x3, out_y3, tex_s0, tex_t0, tex_s3, tex_t3,
  // palette_index, zero pad
  output logic [143:0] m_tdata,
  // palette_valid
  output logic [0:0]   m_tuser
);

  localparam int POS_W  = sse_pkg::POS_W;
  localparam int DIV_W  = sse_pkg::DIV_W;
  localparam int PROD_W = sse_pkg::PROD_W;
  localparam int CNT_W  = sse_pkg::DIV_CNT_W;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(sse_pkg::DIV_STEPS - 1);

  localparam logic signed [POS_W-1:0] LIM_X = POS_W'(SCREEN_WIDTH << FRAC_BITS);
  localparam logic signed [POS_W-1:0] LIM_Y = POS_W'(SCREEN_HEIGHT << FRAC_BITS);

  // Input fields
  logic [1:0]         in_op;
  logic signed [15:0] in_x0, in_y0, in_x3, in_y3;
  logic [8:0]         in_cw, in_ch;
  logic [1:0]         in_flip;
  logic               in_use_pal;
  logic [7:0]         in_pv, in_pt, in_size;

  assign in_op      = s_tuser;
  assign in_x0      = s_tdata[15:0];
  assign in_y0      = s_tdata[31:16];
  assign in_x3      = s_tdata[47:32];
  assign in_y3      = s_tdata[63:48];
  assign in_cw      = s_tdata[72:64];
  assign in_ch      = s_tdata[81:73];
  assign in_flip    = s_tdata[83:82];
  assign in_use_pal = s_tdata[84];
  assign in_pv      = s_tdata[92:85];
  assign in_pt      = s_tdata[100:93];
  assign in_size    = s_tdata[108:101];

  // Quad state
  logic               quad_active;
  logic signed [15:0] origin_x, origin_y;
  logic signed [16:0] span_x, span_y;
  logic [8:0]         width_store, height_store;
  logic [1:0]         flip_store;
  logic [7:0]         palette_offset;
  logic               palette_flag;

  // Sequencer and run registers
  sse_pkg::sse_state_t state, state_next;
  logic                     pt_phase;
  logic [2:0]               job;
  logic [CNT_W-1:0]         div_cnt;
  logic [8:0]               div_rem;
  logic [DIV_W-1:0]         div_quo;
  logic                     div_neg;
  logic signed [PROD_W-1:0] prod;
  logic [7:0]               sx, sy;
  logic [7:0]               run_size;
  logic [7:0]               run_pv;
  logic signed [POS_W-1:0]  pos [4];
  logic [16:0]              texr [4];

  // Output register
  logic [15:0] out_x0, out_y0, out_x3, out_y3;
  logic [16:0] out_s0, out_t0, out_s3, out_t3;
  logic [8:0]  out_pidx;
  logic        out_pvalid;

  assign m_tdata = {3'b000, out_pidx, out_t3, out_s3, out_t0, out_s0,
                    out_y3, out_x3, out_y0, out_x0};
  assign m_tuser = out_pvalid;

  logic out_free, s_accept;
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == sse_pkg::ST_IDLE) && out_free;
  assign s_accept = s_tvalid && s_tready;

  // Quad off the screen
  logic off_screen;
  assign off_screen = (POS_W'(in_x0) >= LIM_X) || (in_x3 < 0) ||
                      (POS_W'(in_y0) >= LIM_Y) || (in_y3 < 0);

  // Run sub-quad on the screen
  logic on_screen;
  assign on_screen = (pos[0] < LIM_X) && (pos[1] >= 0) &&
                     (pos[2] < LIM_Y) && (pos[3] >= 0);

  // Output register loads: a whole quad on intake or a finished run
  logic whole_load, emit_load, out_load;
  assign whole_load = s_accept && in_op == sse_pkg::OP_WHOLE && !off_screen;
  assign emit_load  = (state == sse_pkg::ST_EMIT) && on_screen && out_free;
  assign out_load   = whole_load || emit_load;

  // Edge job decode: job = {axis, texture, corner3}
  logic                     ax, is_tex, c3, fl;
  logic [7:0]               lo;
  logic [4:0]               ext;
  logic [8:0]               hi, dd;
  logic signed [9:0]        n_place;
  logic [8:0]               n_tex;
  logic signed [16:0]       span_sel;
  logic signed [15:0]       org_sel;
  logic signed [POS_W-1:0]  mul_full;
  logic [8:0]               div_den;

  assign ax       = job[2];
  assign is_tex   = job[1];
  assign c3       = job[0];
  assign fl       = flip_store[ax];
  assign lo       = ax ? sy : sx;
  assign ext      = ax ? ({1'b0, run_size[3:0]} + 5'd1) : ({1'b0, run_size[7:4]} + 5'd1);
  assign hi       = 9'(lo) + 9'(ext);
  assign dd       = ax ? height_store : width_store;
  assign span_sel = ax ? span_y : span_x;
  assign org_sel  = ax ? origin_y : origin_x;
  assign div_den  = (pt_phase || !ax) ? width_store : height_store;

  // Pick the texel edge for this corner
  always_comb begin
    if (fl) begin
      n_place = c3 ? ($signed({1'b0, dd}) - $signed({2'b00, lo}))
                   : ($signed({1'b0, dd}) - $signed({1'b0, hi}));
    end else begin
      n_place = c3 ? $signed({1'b0, hi}) : $signed({2'b00, lo});
    end
    n_tex = (fl ^ c3) ? hi : 9'(lo);
  end

  assign mul_full = span_sel * n_place;

  // Divider step
  logic [9:0] div_trial;
  logic       div_ge;
  logic [9:0] div_diff;
  logic       div_last;
  assign div_trial = {div_rem, div_quo[DIV_W-1]};
  assign div_ge    = div_trial >= {1'b0, div_den};
  assign div_diff  = div_trial - {1'b0, div_den};
  assign div_last  = div_cnt == CNT_LAST;

  // Finished quotient as a coordinate
  logic signed [DIV_W:0]   q_signed;
  logic signed [POS_W-1:0] pos_val;
  logic [16:0]             tex_val;
  assign q_signed = div_neg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
  assign pos_val  = POS_W'(org_sel) + POS_W'(q_signed);
  assign tex_val  = (div_quo > DIV_W'(sse_pkg::TEX_ONE)) ? sse_pkg::TEX_ONE : div_quo[16:0];

  // Hold state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sse_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Advance the sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      sse_pkg::ST_IDLE: begin
        if (s_accept && in_op == sse_pkg::OP_RUN && quad_active) begin
          state_next = sse_pkg::ST_DIV;
        end
      end
      sse_pkg::ST_DIV: begin
        if (div_last) begin
          state_next = sse_pkg::ST_STORE;
        end
      end
      sse_pkg::ST_STORE: begin
        if (!pt_phase && job == 3'd7) begin
          state_next = sse_pkg::ST_EMIT;
        end else begin
          state_next = sse_pkg::ST_MUL;
        end
      end
      sse_pkg::ST_MUL:  state_next = sse_pkg::ST_LOAD;
      sse_pkg::ST_LOAD: state_next = sse_pkg::ST_DIV;
      sse_pkg::ST_EMIT: begin
        if (!on_screen || out_free) begin
          state_next = sse_pkg::ST_IDLE;
        end
      end
      default: state_next = sse_pkg::ST_IDLE;
    endcase
  end

  // Datapath, quad state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      quad_active    <= 1'b0;
      origin_x       <= '0;
      origin_y       <= '0;
      span_x         <= '0;
      span_y         <= '0;
      width_store    <= 9'd1;
      height_store   <= 9'd1;
      flip_store     <= '0;
      palette_offset <= '0;
      palette_flag   <= 1'b0;
      pt_phase       <= 1'b0;
      job            <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      // Raise the output on a load, drop it once taken
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        sse_pkg::ST_IDLE: begin
          if (s_accept) begin
            unique case (in_op)
              sse_pkg::OP_START: begin
                if (off_screen) begin
                  quad_active <= 1'b0;
                end else begin
                  quad_active    <= 1'b1;
                  origin_x       <= in_x0;
                  origin_y       <= in_y0;
                  span_x         <= 17'(in_x3) - 17'(in_x0);
                  span_y         <= 17'(in_y3) - 17'(in_y0);
                  width_store    <= (in_cw == 9'd0) ? 9'd1 : in_cw;
                  height_store   <= (in_ch == 9'd0) ? 9'd1 : in_ch;
                  flip_store     <= in_flip;
                  palette_offset <= in_pv;
                  palette_flag   <= in_use_pal;
                end
              end
              sse_pkg::OP_RUN: begin
                if (quad_active) begin
                  run_size <= in_size;
                  run_pv   <= in_pv;
                  div_quo  <= DIV_W'(in_pt);
                  div_rem  <= '0;
                  div_cnt  <= '0;
                  pt_phase <= 1'b1;
                  job      <= '0;
                end
              end
              sse_pkg::OP_WHOLE: begin
                if (!off_screen) begin
                  out_x0     <= in_x0;
                  out_y0     <= in_y0;
                  out_x3     <= in_x3;
                  out_y3     <= in_y3;
                  out_s0     <= in_flip[0] ? sse_pkg::TEX_ONE : 17'd0;
                  out_s3     <= in_flip[0] ? 17'd0 : sse_pkg::TEX_ONE;
                  out_t0     <= in_flip[1] ? sse_pkg::TEX_ONE : 17'd0;
                  out_t3     <= in_flip[1] ? 17'd0 : sse_pkg::TEX_ONE;
                  out_pidx   <= in_use_pal ? {1'b0, in_pv} : 9'd0;
                  out_pvalid <= in_use_pal;
                end
              end
              default: begin
              end
            endcase
          end
        end
        sse_pkg::ST_DIV: begin
          div_rem <= div_ge ? div_diff[8:0] : div_trial[8:0];
          div_quo <= {div_quo[DIV_W-2:0], div_ge};
          div_cnt <= div_cnt + 1'b1;
        end
        sse_pkg::ST_STORE: begin
          if (pt_phase) begin
            sx       <= div_rem[7:0];
            sy       <= div_quo[7:0];
            pt_phase <= 1'b0;
            job      <= '0;
          end else begin
            if (is_tex) begin
              texr[{ax, c3}] <= tex_val;
            end else begin
              pos[{ax, c3}] <= pos_val;
            end
            job <= job + 1'b1;
          end
        end
        sse_pkg::ST_MUL: begin
          if (is_tex) begin
            prod <= $signed({1'b0, n_tex, 16'h0000});
          end else begin
            prod <= mul_full[PROD_W-1:0];
          end
        end
        sse_pkg::ST_LOAD: begin
          div_neg <= prod[PROD_W-1];
          div_quo <= prod[PROD_W-1] ? DIV_W'(-prod) : prod[DIV_W-1:0];
          div_rem <= '0;
          div_cnt <= '0;
        end
        sse_pkg::ST_EMIT: begin
          if (on_screen && out_free) begin
            out_x0     <= sse_pkg::sat16(pos[0]);
            out_x3     <= sse_pkg::sat16(pos[1]);
            out_y0     <= sse_pkg::sat16(pos[2]);
            out_y3     <= sse_pkg::sat16(pos[3]);
            out_s0     <= texr[0];
            out_s3     <= texr[1];
            out_t0     <= texr[2];
            out_t3     <= texr[3];
            out_pidx   <= palette_flag ? (9'(run_pv) + 9'(palette_offset)) : 9'd0;
            out_pvalid <= palette_flag;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Check terms
  logic run_start, tex_in_range;
  assign run_start    = s_accept && in_op == sse_pkg::OP_RUN && quad_active;
  assign tex_in_range = (out_s0 <= sse_pkg::TEX_ONE) && (out_t0 <= sse_pkg::TEX_ONE) &&
                        (out_s3 <= sse_pkg::TEX_ONE) && (out_t3 <= sse_pkg::TEX_ONE);

  // Checks
  `SSE_ASSERT_NR(a_reset_idle, rst |=> (state == sse_pkg::ST_IDLE && !m_tvalid), "busy after reset")
  `SSE_ASSERT(a_run_split, run_start |=> (state == sse_pkg::ST_DIV && pt_phase), "run not started")
  `SSE_ASSERT(a_div_count, (state == sse_pkg::ST_DIV) |-> (div_cnt <= CNT_LAST), "bad divider count")
  `SSE_ASSERT(a_tex_range, m_tvalid |-> tex_in_range, "texture coordinate above one")
  `SSE_ASSERT(a_emit, emit_load |=> (m_tvalid && state == sse_pkg::ST_IDLE), "run not moved out")

endmodule
